FILE: src/u2u8pe_pkg.sv
// ----------------------------------------------------------------------------
// u2u8pe_pkg
// Shared types, codes and helper functions of the UTF-16 to UTF-8 percent
// encoder: byte list of one item, UTF-8 packing, unreserved test, hex digits.
// ----------------------------------------------------------------------------
package u2u8pe_pkg;

  // Output mode register codes
  localparam logic MODE_RAW = 1'b0;
  localparam logic MODE_PCT = 1'b1;

  // Upper 11 bits of a surrogate code unit
  localparam logic [10:0] HI_SURR_TAG = 11'h036;
  localparam logic [10:0] LO_SURR_TAG = 11'h037;

  // Offset of supplementary code points
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // ASCII percent sign
  localparam logic [7:0] PCT_CHAR = 8'h25;

  // Largest byte count of one item: three flushed bytes plus four new ones
  localparam int unsigned MAX_BYTES = 7;

  // One UTF-8 sequence, byte 0 goes out first
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } utf8_t;

  // Surrogate hold state
  typedef struct packed {
    logic       pend;
    logic [9:0] held;
  } surr_t;

  // Byte list that one accepted item produces, plus next hold state
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
    surr_t                     nxt;
  } enc_t;

  // Pack one code point (up to 21 bits) as UTF-8
  function automatic utf8_t utf8_encode(input logic [20:0] c);
    utf8_t r;
    r.b   = '0;
    r.len = 3'd0;
    if (c < 21'h80) begin
      r.b[0] = {1'b0, c[6:0]};
      r.len  = 3'd1;
    end else if (c < 21'h800) begin
      r.b[0] = {3'b110, c[10:6]};
      r.b[1] = {2'b10, c[5:0]};
      r.len  = 3'd2;
    end else if (c < 21'h10000) begin
      r.b[0] = {4'b1110, c[15:12]};
      r.b[1] = {2'b10, c[11:6]};
      r.b[2] = {2'b10, c[5:0]};
      r.len  = 3'd3;
    end else begin
      // also covers units above 0x10FFFF: lead byte may reach 0xF7
      r.b[0] = {5'b11110, c[20:18]};
      r.b[1] = {2'b10, c[17:12]};
      r.b[2] = {2'b10, c[11:6]};
      r.b[3] = {2'b10, c[5:0]};
      r.len  = 3'd4;
    end
    return r;
  endfunction

  // Letters, digits and - . _ ~ pass through in percent mode
  function automatic logic byte_unreserved(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
           (b >= 8'h30 && b <= 8'h39) ||
           b == 8'h2d || b == 8'h2e || b == 8'h5f || b == 8'h7e;
  endfunction

  // Upper-case hex digit
  function automatic logic [7:0] nibble_to_ascii(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'h0, d};
    end else begin
      r = 8'h37 + {4'h0, d};
    end
    return r;
  endfunction

endpackage

FILE: src/u2u8pe_encoder.sv
// ----------------------------------------------------------------------------
// u2u8pe_encoder
// Combinational UTF-8 packing of one code unit: pairs it with a held high
// surrogate, flushes an unpaired one, and gives the byte list of the item.
// ----------------------------------------------------------------------------
module u2u8pe_encoder (
  input  logic [20:0]          code_unit_i,
  input  logic                 end_of_string_i,
  input  u2u8pe_pkg::surr_t    state_i,
  output u2u8pe_pkg::enc_t     enc_o
);

  logic              is_lo;
  logic              is_hi;
  logic              pair;
  logic              flush;
  logic              hold_new;
  logic [20:0]       pair_cp;
  u2u8pe_pkg::utf8_t flush_seq;
  u2u8pe_pkg::utf8_t new_seq;
  logic [2:0]        new_len;

  assign is_lo = (code_unit_i[20:10] == u2u8pe_pkg::LO_SURR_TAG);
  assign is_hi = (code_unit_i[20:10] == u2u8pe_pkg::HI_SURR_TAG);

  // Held high surrogate either pairs with a low one or is flushed
  assign pair     = state_i.pend && is_lo;
  assign flush    = state_i.pend && !is_lo;
  assign hold_new = !pair && is_hi && !end_of_string_i;

  assign pair_cp = {1'b0, state_i.held, code_unit_i[9:0]} + u2u8pe_pkg::SUPP_BASE;

  assign flush_seq = u2u8pe_pkg::utf8_encode({u2u8pe_pkg::HI_SURR_TAG, state_i.held});
  assign new_seq   = u2u8pe_pkg::utf8_encode(pair ? pair_cp : code_unit_i);
  assign new_len   = hold_new ? 3'd0 : new_seq.len;

  // Byte list: flushed sequence (always three bytes) ahead of the new one
  always_comb begin
    enc_o.bytes = '0;
    if (flush) begin
      enc_o.bytes[0] = flush_seq.b[0];
      enc_o.bytes[1] = flush_seq.b[1];
      enc_o.bytes[2] = flush_seq.b[2];
      enc_o.bytes[3] = new_seq.b[0];
      enc_o.bytes[4] = new_seq.b[1];
      enc_o.bytes[5] = new_seq.b[2];
      enc_o.bytes[6] = new_seq.b[3];
      enc_o.cnt      = 3'd3 + new_len;
    end else begin
      enc_o.bytes[0] = new_seq.b[0];
      enc_o.bytes[1] = new_seq.b[1];
      enc_o.bytes[2] = new_seq.b[2];
      enc_o.bytes[3] = new_seq.b[3];
      enc_o.cnt      = new_len;
    end
    enc_o.nxt.pend = hold_new;
    enc_o.nxt.held = hold_new ? code_unit_i[9:0] : 10'h000;
  end

endmodule

FILE: src/utf16_to_utf8_percent_encoder_unit.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_percent_encoder_unit
// UTF-16 / wide code unit to UTF-8 encoder with optional percent encoding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one code unit per beat with
//   its end-of-string mark. Output channel (out_valid_o / out_stall_i) gives
//   one character per beat; last_of_run_o marks the final beat of an item.
//   The cfg channel writes output_mode (0 raw UTF-8, 1 percent form); write
//   it only while no item is in flight. cfg_ready_o is always high.
//   The first result beat of an item passes the run register, which loads
//   at the accepting edge, and then the output register, from which the
//   receiver takes it.
//   Throughput: one output beat per cycle while the receiver does not stall.
//   An item holds the input until all its result beats (1 to 21) have left
//   the run; a held high surrogate yields no beat. The next item is taken in
//   the cycle the final beat of the current one moves to the output register.
//   A receiver stall freezes the output register and the run register, and
//   the input stalls once the run is busy.
//   Reset clears the mode to raw, drops any held surrogate and empties both
//   the run and the output register.
// ----------------------------------------------------------------------------
module utf16_to_utf8_percent_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [20:0] code_unit_i,
  input  logic        end_of_string_i,
  // output beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o
);

  logic                                   mode_q;
  u2u8pe_pkg::surr_t                      surr_q, surr_d;
  u2u8pe_pkg::enc_t                       enc;

  logic                                   run_valid_q, run_valid_d;
  logic [u2u8pe_pkg::MAX_BYTES-1:0][7:0]  run_bytes_q, run_bytes_d;
  logic [2:0]                             run_cnt_q, run_cnt_d;
  logic [2:0]                             run_idx_q, run_idx_d;
  logic [1:0]                             run_sub_q, run_sub_d;

  logic                                   out_valid_q, out_valid_d;
  logic [7:0]                             out_byte_q, out_byte_d;
  logic                                   out_last_q, out_last_d;

  logic                                   in_accept;
  logic                                   out_adv;
  logic                                   emit;
  logic [7:0]                             cur_byte;
  logic                                   expand;
  logic                                   char_last;
  logic                                   run_last;
  logic [7:0]                             cur_char;

  // Mode register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= u2u8pe_pkg::MODE_RAW;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // Packing of the incoming unit
  u2u8pe_encoder u_encoder (
    .code_unit_i     (code_unit_i),
    .end_of_string_i (end_of_string_i),
    .state_i         (surr_q),
    .enc_o           (enc)
  );

  // Character selection for the current run position
  assign cur_byte  = run_bytes_q[run_idx_q];
  assign expand    = (mode_q == u2u8pe_pkg::MODE_PCT) &&
                     !u2u8pe_pkg::byte_unreserved(cur_byte);
  assign char_last = !expand || (run_sub_q == 2'd2);
  assign run_last  = char_last && (run_idx_q == run_cnt_q - 3'd1);

  always_comb begin
    if (!expand) begin
      cur_char = cur_byte;
    end else begin
      case (run_sub_q)
        2'd0:    cur_char = u2u8pe_pkg::PCT_CHAR;
        2'd1:    cur_char = u2u8pe_pkg::nibble_to_ascii(cur_byte[7:4]);
        default: cur_char = u2u8pe_pkg::nibble_to_ascii(cur_byte[3:0]);
      endcase
    end
  end

  // Handshake
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign emit       = run_valid_q && out_adv;
  assign in_stall_o = run_valid_q && !(emit && run_last);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Surrogate hold state
  assign surr_d = in_accept ? enc.nxt : surr_q;

  // Run register: step through bytes and percent characters
  always_comb begin
    run_valid_d = run_valid_q;
    run_bytes_d = run_bytes_q;
    run_cnt_d   = run_cnt_q;
    run_idx_d   = run_idx_q;
    run_sub_d   = run_sub_q;
    if (emit) begin
      if (run_last) begin
        run_valid_d = 1'b0;
      end else if (char_last) begin
        run_idx_d = run_idx_q + 3'd1;
        run_sub_d = 2'd0;
      end else begin
        run_sub_d = run_sub_q + 2'd1;
      end
    end
    if (in_accept && (enc.cnt != 3'd0)) begin
      run_valid_d = 1'b1;
      run_bytes_d = enc.bytes;
      run_cnt_d   = enc.cnt;
      run_idx_d   = 3'd0;
      run_sub_d   = 2'd0;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_char;
      out_last_d  = run_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surr_q      <= '0;
      run_valid_q <= 1'b0;
      run_cnt_q   <= 3'd0;
      run_idx_q   <= 3'd0;
      run_sub_q   <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      surr_q      <= surr_d;
      run_valid_q <= run_valid_d;
      run_cnt_q   <= run_cnt_d;
      run_idx_q   <= run_idx_d;
      run_sub_q   <= run_sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    run_bytes_q <= run_bytes_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  // Input only stalls behind a busy run
  a_stall_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> run_valid_q)
    else $error("input stalled with an empty run");

  // Run position stays inside its byte list
  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> (run_cnt_q != 3'd0 && run_idx_q < run_cnt_q))
    else $error("run position out of range");

  // A high surrogate without end mark and nothing held is held next cycle
  a_hold_surr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !surr_q.pend && !end_of_string_i &&
     code_unit_i[20:10] == u2u8pe_pkg::HI_SURR_TAG) |=> surr_q.pend)
    else $error("high surrogate not held");

  // A run that stalls on the output does not move
  a_run_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_valid_q && out_valid_q && out_stall_i) |=>
      ($stable(run_idx_q) && $stable(run_sub_q) && run_valid_q))
    else $error("run advanced under output stall");
`endif

endmodule

FILE: test/utf8_stream_checker.sv
// ----------------------------------------------------------------------------
// utf8_stream_checker
// Watches the config, input and output channels of the UTF-16 to UTF-8
// percent encoder. It predicts the beats that each accepted code unit should
// produce and compares every output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [20:0] code_unit_i,
  input  logic        end_of_string_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_of_run_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One UTF-8 sequence, b[0] leaves first
  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } utf8_seq_t;

  // One predicted output beat
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } beat_t;

  beat_t      expected_beats[$];
  logic       mode_q;
  logic       pend_q;
  logic [9:0] held_q;
  int         mismatches;

  // UTF-8 form of one code point; anything at or above 0x10000 takes 4 bytes
  function automatic utf8_seq_t utf8_of(input logic [20:0] c);
    utf8_seq_t s;
    s = '0;
    if (c < 21'h80) begin
      s.n    = 3'd1;
      s.b[0] = {1'b0, c[6:0]};
    end else if (c < 21'h800) begin
      s.n    = 3'd2;
      s.b[0] = {3'b110, c[10:6]};
      s.b[1] = {2'b10, c[5:0]};
    end else if (c < 21'h10000) begin
      s.n    = 3'd3;
      s.b[0] = {4'b1110, c[15:12]};
      s.b[1] = {2'b10, c[11:6]};
      s.b[2] = {2'b10, c[5:0]};
    end else begin
      s.n    = 3'd4;
      s.b[0] = {5'b11110, c[20:18]};
      s.b[1] = {2'b10, c[17:12]};
      s.b[2] = {2'b10, c[11:6]};
      s.b[3] = {2'b10, c[5:0]};
    end
    return s;
  endfunction

  // Letters, digits and - . _ ~ go out unescaped
  function automatic logic is_url_safe(input logic [7:0] c);
    return c inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39],
                     8'h2d, 8'h2e, 8'h5f, 8'h7e};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? 8'h30 + {4'h0, d} : 8'h41 + {4'h0, d} - 8'd10;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Update the surrogate hold and queue the beats of one code unit
  task automatic predict_item(input logic [20:0] cu, input logic eos);
    logic [7:0] raw [7];
    beat_t      run [21];
    utf8_seq_t  s;
    logic       taken;
    int         nb;
    int         nr;
    int         i;
    nb    = 0;
    nr    = 0;
    taken = 1'b0;
    // a held high surrogate either pairs up or is flushed alone
    if (pend_q) begin
      if (cu[20:10] == u2u8pe_pkg::LO_SURR_TAG) begin
        s     = utf8_of({1'b0, held_q, cu[9:0]} + u2u8pe_pkg::SUPP_BASE);
        taken = 1'b1;
      end else begin
        s = utf8_of({5'b00000, u2u8pe_pkg::HI_SURR_TAG[5:0], held_q});
      end
      pend_q = 1'b0;
      held_q = '0;
      for (i = 0; i < int'(s.n); i++) begin
        raw[nb] = s.b[i];
        nb++;
      end
    end
    // new unit: hold a high surrogate unless it ends the string
    if (!taken) begin
      if (cu[20:10] == u2u8pe_pkg::HI_SURR_TAG && !eos) begin
        pend_q = 1'b1;
        held_q = cu[9:0];
      end else begin
        s = utf8_of(cu);
        for (i = 0; i < int'(s.n); i++) begin
          raw[nb] = s.b[i];
          nb++;
        end
      end
    end
    // expand to output characters
    for (i = 0; i < nb; i++) begin
      if (mode_q == u2u8pe_pkg::MODE_RAW || is_url_safe(raw[i])) begin
        run[nr] = '{raw[i], 1'b0};
        nr++;
      end else begin
        run[nr]     = '{u2u8pe_pkg::PCT_CHAR, 1'b0};
        run[nr + 1] = '{hex_char(raw[i][7:4]), 1'b0};
        run[nr + 2] = '{hex_char(raw[i][3:0]), 1'b0};
        nr += 3;
      end
    end
    if (nr > 0) begin
      run[nr - 1].last = 1'b1;
    end
    for (i = 0; i < nr; i++) begin
      expected_beats.insert(expected_beats.size(), run[i]);
    end
  endtask

  task automatic check_beat();
    beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("beat with nothing expected: byte %02h last %0b",
                                out_byte_i, last_of_run_i));
    end else begin
      want = expected_beats.pop_front();
      if (out_byte_i !== want.ch) begin
        report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_i, want.ch));
      end
      if (last_of_run_i !== want.last) begin
        report_mismatch($sformatf("last_of_run %0b, expected %0b (byte %02h)",
                                  last_of_run_i, want.last, want.ch));
      end
    end
  endtask

  // Sample all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       = u2u8pe_pkg::MODE_RAW;
      pend_q       = 1'b0;
      held_q       = '0;
      mismatches   = 0;
      expected_beats.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_item(code_unit_i, end_of_string_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_beat();
      end
      pending_o    <= expected_beats.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives code unit strings into the UTF-16 to UTF-8 percent encoder in both
// output modes: a directed set of edge values, then random strings under
// several idle and stall patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 60;
  localparam int PRESS_ITEMS   = 40;
  localparam int DIR_COUNT     = 13;

  // Range edges, a pair, a held unit flushed before a 4-byte unit,
  // a lone low surrogate and a high surrogate that ends the string
  localparam logic [20:0] DIR_UNITS [DIR_COUNT] = '{
    21'h000000, 21'h00007f, 21'h000080, 21'h0007ff, 21'h000800,
    21'h00ffff, 21'h10ffff, 21'h00d83d, 21'h00de00, 21'h00dbff,
    21'h1fffff, 21'h00dc00, 21'h00d800
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_data_i      = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic [20:0] code_unit_i     = '0;
  logic        end_of_string_i = 1'b0;
  logic        out_stall_i     = 1'b0;
  logic        cfg_ready_o;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o;

  int fail_count;
  int pending_beats;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int holds_asked   = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int units_sent    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  utf16_to_utf8_percent_encoder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .code_unit_i     (code_unit_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o)
  );

  utf8_stream_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .code_unit_i     (code_unit_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_i      (out_byte_o),
    .last_of_run_i   (last_of_run_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_beats)
  );

  // Receiver: random stall, or a long hold-off when one is asked for
  always @(posedge clk_i) begin
    if (holds_asked != holds_done) begin
      hold_left  = HOLD_CYCLES;
      holds_done = holds_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input beat, after random sender idle cycles
  task automatic drive_unit(input logic [20:0] cu, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    code_unit_i     <= cu;
    end_of_string_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    units_sent++;
  endtask

  task automatic write_mode(input logic m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stop sending and wait until every predicted beat is out
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_beats != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_directed();
    int i;
    for (i = 0; i < DIR_COUNT; i++) begin
      drive_unit(DIR_UNITS[i], i == DIR_COUNT - 1);
    end
  endtask

  // Random strings of 1..8 positions, the last marked end of string unless
  // raw noise (random mark); mostly well-formed text, some broken pairs
  task automatic send_random(input int count);
    int   stop;
    int   len;
    int   k;
    int   r;
    logic fin;
    stop = units_sent + count;
    while (units_sent < stop) begin
      len = $urandom_range(8, 1);
      for (k = 0; k < len; k++) begin
        fin = (k == len - 1);
        r   = $urandom_range(99);
        if (r < 25) begin
          drive_unit(21'($urandom_range(8'h7f, 0)), fin);
        end else if (r < 40) begin
          drive_unit(21'($urandom_range(21'h7ff, 21'h80)), fin);
        end else if (r < 55) begin
          drive_unit(21'($urandom_range(21'hffff, 21'h800)), fin);
        end else if (r < 75) begin
          // surrogate pair; now and then the high half ends the string
          drive_unit({u2u8pe_pkg::HI_SURR_TAG, 10'($urandom_range(1023))},
                     $urandom_range(9) == 0);
          drive_unit({u2u8pe_pkg::LO_SURR_TAG, 10'($urandom_range(1023))}, fin);
        end else if (r < 80) begin
          drive_unit({u2u8pe_pkg::HI_SURR_TAG, 10'($urandom_range(1023))}, fin);
        end else if (r < 85) begin
          drive_unit({u2u8pe_pkg::LO_SURR_TAG, 10'($urandom_range(1023))}, fin);
        end else if (r < 93) begin
          drive_unit(21'($urandom_range(21'h1fffff, 21'h10000)), fin);
        end else begin
          drive_unit(21'($urandom()), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed set in both modes
    write_mode(u2u8pe_pkg::MODE_RAW);
    run_directed();
    settle();
    write_mode(u2u8pe_pkg::MODE_PCT);
    run_directed();
    settle();

    // no idling
    send_random(PHASE_ITEMS);
    settle();

    // sender mostly idle
    write_mode(u2u8pe_pkg::MODE_RAW);
    send_idle_pct = 71;
    send_random(PHASE_ITEMS);
    settle();

    // receiver mostly stalling
    write_mode(u2u8pe_pkg::MODE_PCT);
    send_idle_pct = 0;
    stall_pct     = 71;
    send_random(PHASE_ITEMS);
    settle();

    // both sides idle now and then
    write_mode(u2u8pe_pkg::MODE_RAW);
    send_idle_pct = 31;
    stall_pct     = 31;
    send_random(PHASE_ITEMS);
    settle();

    // long receiver hold-off while the sender keeps pushing
    write_mode(u2u8pe_pkg::MODE_PCT);
    send_idle_pct = 0;
    stall_pct     = 0;
    holds_asked++;
    send_random(PRESS_ITEMS);
    settle();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
